@@ sv/txcw_pkg.sv @@
package txcw_pkg;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL_PRE,
    ST_SCROLL,
    ST_CLEAR
  } state_e;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  SPACE_CODE   = 8'd32;
  localparam logic [7:0]  ATTR_RESET   = 8'h07;
  localparam logic [15:0] RESET_CELL   = 16'h0720;

endpackage

@@ sv/text_console_writer.sv @@
// Text-mode console: a ROW_COUNT x COLUMN_COUNT screen of 16-bit cells
// (attribute in the high byte, character in the low byte) kept in one
// synchronous RAM, plus a cursor. Every input transaction yields exactly one
// output transaction carrying the cursor after the operation. A plain put
// character is one RAM write; a read passes through ST_READ because of the
// registered RAM read; an unused op only reports the cursor. A put that runs
// past the last row scrolls: the RAM is walked once, copying each row up and
// blanking the bottom row, during which no input is taken. A clear walks the
// RAM once writing blanks in the current attribute. After reset a clearing
// pass fills the screen with 0x0720 before the first input transaction is
// accepted; attribute writes are taken at any time. A new input transaction
// is accepted while the previous result is being taken in the same cycle.
module text_console_writer import txcw_pkg::*; #(
  parameter int unsigned ROW_COUNT    = 25,
  parameter int unsigned COLUMN_COUNT = 80
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // attribute register
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  character_i,
  input  logic [10:0] cell_index_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] cell_value_o,
  output logic [4:0]  row_now_o,
  output logic [6:0]  column_now_o,
  output logic        scrolled_o
);

  localparam int unsigned Total = ROW_COUNT * COLUMN_COUNT;
  localparam int unsigned AW    = $clog2(Total);
  localparam int unsigned RW    = $clog2(ROW_COUNT);
  localparam int unsigned CW    = $clog2(COLUMN_COUNT);
  // index compare width: the 11-bit field or the depth, plus one so the cell
  // count itself fits
  localparam int unsigned IW    = ((AW > 11) ? AW : 11) + 1;

  // control state
  state_e          state_q, state_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic [RW-1:0]   row_q, row_d;
  logic [CW-1:0]   col_q, col_d;
  logic [7:0]      attr_q;
  logic            out_valid_q, out_valid_d;

  // payload
  logic [15:0]     out_cell_q, out_cell_d;
  logic [RW-1:0]   out_row_q, out_row_d;
  logic [CW-1:0]   out_col_q, out_col_d;
  logic            out_scr_q, out_scr_d;
  logic            rd_ok_q, rd_ok_d;

  // ram interface
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [15:0]     ram_wdata, ram_rdata;

  logic            out_free, load_out, cnt_last;
  logic [15:0]     blank_cell;
  logic [AW-1:0]   cursor_pos;
  logic [AW:0]     scroll_next;
  logic [IW-1:0]   idx_ext;
  logic [RW+4:0]   row_wide;

  txcw_screen_ram #(
    .Depth (Total),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign blank_cell  = {attr_q, SPACE_CODE};
  assign cursor_pos  = AW'(int'(row_q) * COLUMN_COUNT + int'(col_q));
  assign cnt_last    = (cnt_q == AW'(Total - 1));
  // scroll prefetch: the source of the next destination, one row below
  assign scroll_next = (AW + 1)'(cnt_q) + (AW + 1)'(COLUMN_COUNT + 1);
  assign idx_ext     = IW'(cell_index_i);
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    rd_ok_d    = rd_ok_q;
    ram_we     = 1'b0;
    ram_waddr  = cursor_pos;
    ram_wdata  = {attr_q, character_i};
    ram_re     = 1'b0;
    ram_raddr  = idx_ext[AW-1:0];
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    out_cell_d = 16'd0;
    out_scr_d  = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        // clearing pass after reset, fixed reset pattern
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = RESET_CELL;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          unique case (op_i)
            OP_PUT: begin
              ram_we = (character_i != NEWLINE_CODE);
              if (character_i == NEWLINE_CODE || col_q == CW'(COLUMN_COUNT - 1)) begin
                col_d = '0;
                if (row_q == RW'(ROW_COUNT - 1)) begin
                  // last row: cursor stays, screen moves up
                  state_d = ST_SCROLL_PRE;
                end else begin
                  row_d    = row_q + RW'(1);
                  load_out = 1'b1;
                end
              end else begin
                col_d    = col_q + CW'(1);
                load_out = 1'b1;
              end
            end
            OP_CLEAR: begin
              row_d   = '0;
              col_d   = '0;
              cnt_d   = '0;
              state_d = ST_CLEAR;
            end
            OP_READ: begin
              ram_re  = 1'b1;
              rd_ok_d = (idx_ext < IW'(Total));
              state_d = ST_READ;
            end
            default: begin
              // unused op: report the cursor only
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_cell_d = rd_ok_q ? ram_rdata : 16'd0;
        load_out   = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_SCROLL_PRE: begin
        // fetch the first source cell, start of row one
        ram_re    = 1'b1;
        ram_raddr = AW'(COLUMN_COUNT);
        cnt_d     = '0;
        state_d   = ST_SCROLL;
      end
      ST_SCROLL: begin
        // write at cnt, read ahead at cnt+1+columns; reads stay above writes
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = (cnt_q < AW'(Total - COLUMN_COUNT)) ? ram_rdata : blank_cell;
        ram_re    = (scroll_next < (AW + 1)'(Total));
        ram_raddr = scroll_next[AW-1:0];
        cnt_d     = cnt_q + AW'(1);
        if (cnt_last) begin
          cnt_d     = '0;
          out_scr_d = 1'b1;
          load_out  = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = blank_cell;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_last) begin
          cnt_d    = '0;
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // result carries the cursor as left by this operation
    out_row_d = row_d;
    out_col_d = col_d;

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      attr_q      <= ATTR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    rd_ok_q <= rd_ok_d;
    if (load_out) begin
      out_cell_q <= out_cell_d;
      out_row_q  <= out_row_d;
      out_col_q  <= out_col_d;
      out_scr_q  <= out_scr_d;
    end
  end

  // row is masked or zero-extended to the 5-bit field
  assign row_wide     = (RW + 5)'(out_row_q);
  assign out_valid_o  = out_valid_q;
  assign cell_value_o = out_cell_q;
  assign row_now_o    = row_wide[4:0];
  assign column_now_o = 7'(out_col_q);
  assign scrolled_o   = out_scr_q;

  // cursor never leaves the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(row_q) < ROW_COUNT) && (int'(col_q) < COLUMN_COUNT))
    else $error("cursor out of range");

  // a pending result always matches the live cursor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_row_q == row_q) && (out_col_q == col_q))
    else $error("result cursor differs from cursor");

  // no input transaction before the reset clearing pass ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> !in_ready_o)
    else $error("input accepted during clearing pass");

  // a scroll result reports the last row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_scr_q) |-> (row_q == RW'(ROW_COUNT - 1)) && (col_q == '0))
    else $error("scroll result with wrong cursor");

endmodule

@@ sv/txcw_screen_ram.sv @@
module txcw_screen_ram import txcw_pkg::*; #(
  parameter int unsigned Depth = 2000,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [15:0]      wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [15:0]      rdata_o
);

  logic [15:0] mem_q [Depth];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ bench/text_console_writer_tb.sv @@
module text_console_writer_tb;
  import txcw_pkg::*;

  localparam int ROWS           = 25;
  localparam int COLS           = 80;
  localparam int CELL_TOTAL     = ROWS * COLS;
  localparam int PHASE_ITEMS    = 475;
  localparam int HOLD_CYCLES    = 400;
  // a scroll or a clear walks the whole screen with no transaction
  localparam int WATCHDOG_LIMIT = 20000;
  // op code the block leaves unused
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // one output transaction, field by field
  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  row;
    logic [6:0]  col;
    logic        scrolled;
  } console_result_t;

  // one row of the directed stimulus; typed rows carry their own expectation
  typedef struct {
    logic [1:0]      op;
    logic [7:0]      ch;
    logic [10:0]     idx;
    bit              typed;
    console_result_t want;
  } directed_row_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [7:0]  cfg_wdata_i  = 8'h00;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i         = OP_PUT;
  logic [7:0]  character_i  = 8'h00;
  logic [10:0] cell_index_i = 11'd0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [15:0] cell_value_o;
  logic [4:0]  row_now_o;
  logic [6:0]  column_now_o;
  logic        scrolled_o;

  text_console_writer #(
    .ROW_COUNT    (ROWS),
    .COLUMN_COUNT (COLS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .character_i  (character_i),
    .cell_index_i (cell_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cell_value_o (cell_value_o),
    .row_now_o    (row_now_o),
    .column_now_o (column_now_o),
    .scrolled_o   (scrolled_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // console predictor: its own screen, cursor and attribute
  // ---------------------------------------------------------------------
  logic [15:0] screen_mem [CELL_TOTAL];
  int          cur_row;
  int          cur_col;
  logic [7:0]  attr_reg;

  // expectations in acceptance order
  console_result_t pending_results [$];

  int error_count    = 0;
  int sender_idle    = 0;
  int recv_idle_pct  = 0;
  bit long_line      = 1'b0;

  // cursor to column zero of the next row, scrolling past the last row
  function automatic logic next_line();
    int i;
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (i = 0; i < CELL_TOTAL - COLS; i++) screen_mem[i] = screen_mem[i + COLS];
      for (i = CELL_TOTAL - COLS; i < CELL_TOTAL; i++) screen_mem[i] = {attr_reg, SPACE_CODE};
      cur_row = ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // applies one input transaction to the predicted console, returns the result
  function automatic console_result_t console_apply(logic [1:0] op, logic [7:0] ch,
                                                    logic [10:0] idx);
    console_result_t r;
    int i;
    r = '0;
    case (op)
      OP_PUT: begin
        if (ch == NEWLINE_CODE) begin
          r.scrolled = next_line();
        end else begin
          screen_mem[cur_row * COLS + cur_col] = {attr_reg, ch};
          cur_col++;
          if (cur_col >= COLS) r.scrolled = next_line();
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < CELL_TOTAL; i++) screen_mem[i] = {attr_reg, SPACE_CODE};
        cur_row = 0;
        cur_col = 0;
      end
      OP_READ: begin
        if (idx < CELL_TOTAL) r.cell_value = screen_mem[idx];
      end
      default: ;  // unused op leaves everything alone
    endcase
    r.row = cur_row[4:0];
    r.col = cur_col[6:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // mismatch reporting and the result checker
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  console_result_t head_result;

  // sampled mid-cycle: a transaction seen here is taken at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result cell 0x%0h row %0d col %0d",
                                  cell_value_o, row_now_o, column_now_o));
      end else begin
        head_result = pending_results.pop_front();
        compare_field("cell_value", int'(cell_value_o), int'(head_result.cell_value));
        compare_field("row_now", int'(row_now_o), int'(head_result.row));
        compare_field("column_now", int'(column_now_o), int'(head_result.col));
        compare_field("scrolled", int'(scrolled_o), int'(head_result.scrolled));
      end
    end
  end

  // watchdog: cycles in a row with no transaction on either channel
  int quiet_cycles = 0;

  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------
  bit hold_toggle = 1'b0;
  bit hold_seen   = 1'b0;
  int hold_left   = 0;

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_toggle != hold_seen) begin
      // long hold-off so the block backs up and stalls its input
      hold_seen   <= hold_toggle;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------
  // offers one transaction, returns at the edge where it was taken;
  // valid stays high so a back-to-back transaction needs no second drive
  task automatic send_item(input logic [1:0] op, input logic [7:0] ch, input logic [10:0] idx,
                           input bit typed, input console_result_t want);
    int gap;
    console_result_t predicted;
    gap = 0;
    while ($urandom_range(99) < sender_idle) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    character_i  <= ch;
    cell_index_i <= idx;
    do @(negedge clk_i); while (!in_ready_o);
    // taken at the coming edge: update the predictor now, in order
    predicted = console_apply(op, ch, idx);
    pending_results.push_back(typed ? want : predicted);
    @(posedge clk_i);
  endtask

  // attribute writes only once the block has drained
  task automatic set_attribute(input logic [7:0] value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    attr_reg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // random traffic: mostly text with reads, rare clears and unused ops
  task automatic run_random(input int count);
    int k;
    int pick;
    int lo;
    logic [1:0]  op;
    logic [7:0]  ch;
    logic [10:0] idx;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(999);
      ch   = 8'($urandom_range(255));
      idx  = 11'($urandom_range(2047));
      if (pick < 4) begin
        op = OP_CLEAR;
      end else if (pick < 34) begin
        op = OP_UNUSED;
      end else if (pick < 400) begin
        op   = OP_READ;
        pick = $urandom_range(99);
        if (pick < 45) begin
          // around the cursor, where fresh text and scrolled rows sit
          lo  = (cur_row >= 2) ? (cur_row - 2) * COLS : 0;
          idx = 11'(lo + int'($urandom_range(cur_row * COLS + COLS - 1 - lo)));
        end else if (pick < 90) begin
          idx = 11'($urandom_range(CELL_TOTAL - 1));
        end else begin
          idx = 11'($urandom_range(2047, CELL_TOTAL));
        end
      end else begin
        op = OP_PUT;
        // pick the line style at column zero: mostly short lines, some that wrap
        if (cur_col == 0) long_line = ($urandom_range(9) == 0);
        if (!long_line && $urandom_range(99) < 30) ch = NEWLINE_CODE;
      end
      send_item(op, ch, idx, 1'b0, '0);
    end
  endtask

  // directed rows: reset contents, out-of-range reads, unused op,
  // extreme characters and indexes, newline, clear
  directed_row_t directed_rows [25] = '{
    '{OP_READ,   8'h00, 11'd0,    1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0}},
    '{OP_READ,   8'h00, 11'd1999, 1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0}},
    '{OP_READ,   8'h00, 11'd2000, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    '{OP_READ,   8'hFF, 11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    '{OP_UNUSED, 8'h41, 11'd5,    1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    '{OP_PUT,    8'h00, 11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd1, 1'b0}},
    '{OP_PUT,    8'hFF, 11'd0,    1'b1, '{16'h0000, 5'd0, 7'd2, 1'b0}},
    '{OP_PUT,    8'h80, 11'd0,    1'b1, '{16'h0000, 5'd0, 7'd3, 1'b0}},
    '{OP_PUT,    8'h7F, 11'd0,    1'b0, '0},
    '{OP_READ,   8'h00, 11'd0,    1'b1, '{16'h0700, 5'd0, 7'd4, 1'b0}},
    '{OP_READ,   8'h00, 11'd1,    1'b1, '{16'h07FF, 5'd0, 7'd4, 1'b0}},
    '{OP_READ,   8'h00, 11'd2,    1'b1, '{16'h0780, 5'd0, 7'd4, 1'b0}},
    '{OP_READ,   8'h00, 11'd3,    1'b0, '0},
    '{OP_PUT,    8'h0A, 11'd0,    1'b0, '0},
    '{OP_PUT,    8'h55, 11'h555,  1'b0, '0},
    '{OP_PUT,    8'hAA, 11'h2AA,  1'b0, '0},
    '{OP_READ,   8'h00, 11'd80,   1'b0, '0},
    '{OP_READ,   8'h00, 11'd81,   1'b0, '0},
    '{OP_UNUSED, 8'hFF, 11'd2047, 1'b0, '0},
    '{OP_READ,   8'h55, 11'd4,    1'b0, '0},
    '{OP_CLEAR,  8'hFF, 11'd2047, 1'b0, '0},
    '{OP_READ,   8'h00, 11'd0,    1'b0, '0},
    '{OP_READ,   8'h00, 11'd81,   1'b0, '0},
    '{OP_PUT,    8'h0A, 11'd0,    1'b0, '0},
    '{OP_READ,   8'h00, 11'd1999, 1'b0, '0}
  };

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin : main_seq
    int i;
    // predictor starts from the reset screen
    for (i = 0; i < CELL_TOTAL; i++) screen_mem[i] = RESET_CELL;
    cur_row  = 0;
    cur_col  = 0;
    attr_reg = ATTR_RESET;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles often, receiver stalls a lot
    sender_idle = 35;
    recv_idle_pct <= 81;
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].idx,
                directed_rows[i].typed, directed_rows[i].want);

    set_attribute(8'hFF);
    run_random(PHASE_ITEMS);

    // the other way round
    set_attribute(8'h00);
    sender_idle = 81;
    recv_idle_pct <= 35;
    run_random(PHASE_ITEMS);

    // no idling, with one long receiver hold-off at the start
    set_attribute(8'($urandom_range(254, 1)));
    sender_idle = 0;
    recv_idle_pct <= 0;
    hold_toggle <= ~hold_toggle;
    run_random(PHASE_ITEMS);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/txcw_pkg.sv
sv/txcw_screen_ram.sv
sv/text_console_writer.sv
bench/text_console_writer_tb.sv
